// ===== rtl/normal_cdf_approximation_macros.svh =====
// Assertion helpers for the RTL of the normal CDF block.
`ifndef NORMAL_CDF_APPROXIMATION_MACROS_SVH
`define NORMAL_CDF_APPROXIMATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ncdf_pkg.sv =====
package ncdf_pkg;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] ISQ2 = 32'd3037000500;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam longint unsigned P_WIDE =
    (64'd3275911 * 64'd1073741824 + 64'd5000000) / 64'd10000000;
  localparam logic [28:0] P_Q30 = 29'(P_WIDE);

  // At or above 31*ln2 the exponential underflows to zero.
  localparam logic [37:0] EXP_LIMIT = 38'(64'd31 * 64'd744261118);

  localparam longint unsigned A1_MAG =
    (64'd254829592 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A2_MAG =
    (64'd284496736 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A3_MAG =
    (64'd1421413741 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A4_MAG =
    (64'd1453152027 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A5_MAG =
    (64'd1061405429 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;

  typedef logic signed [33:0] poly_t;

  localparam poly_t A1_Q30 = $signed(34'(A1_MAG));
  localparam poly_t A2_Q30 = -$signed(34'(A2_MAG));
  localparam poly_t A3_Q30 = $signed(34'(A3_MAG));
  localparam poly_t A4_Q30 = -$signed(34'(A4_MAG));
  localparam poly_t A5_Q30 = $signed(34'(A5_MAG));

  // Coefficient added after each Horner multiply, starting from a5.
  localparam poly_t HORNER_ADD [4] = '{A4_Q30, A3_Q30, A2_Q30, A1_Q30};

  // Range-reduced exponent travelling alongside the series evaluation.
  typedef struct packed {
    logic [29:0] r;
    logic [4:0]  k;
    logic        big;
  } exp_ctl_t;

endpackage

// ===== rtl/normal_cdf_approximation.sv =====
// Throughput: one beat per cycle while the skid entry is free; the 31-stage
// reciprocal divider and the 36-stage exponential series are fully pipelined,
// one stage per register.
// A two-entry output buffer lets input beats flow while one result waits.
// Reset (rst_n low at a clock edge) empties the pipeline and the output buffer.
`include "normal_cdf_approximation_macros.svh"

module normal_cdf_approximation
  import ncdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [31:0] in_tdata,   // [31:0] x_value
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata   // [31:0] cdf_value
);

  localparam int LAT = 48;

  logic             en;
  logic [LAT:1]     vld_r;
  logic [LAT:1]     neg_r;
  logic [31:0]      ax;
  logic [31:0]      ax_r;
  logic [63:0]      zp_r;
  logic [63:0]      up_r;
  logic [33:0]      z_r;
  logic [37:0]      u_r;
  logic [63:0]      pzp_r;
  logic [32:0]      pz;
  logic [32:0]      d_nxt;

  logic [33:0]      dv_rem_r [0:30];
  logic [32:0]      dv_d_r   [0:30];
  logic [30:0]      dv_nlo_r [0:30];
  logic [30:0]      dv_q_r   [1:31];

  logic [63:0]      pa_prod_r [0:4];
  logic             pa_neg_r  [0:4];
  logic [30:0]      pa_t_r    [0:3];
  poly_t            ph_s_r    [0:4];
  logic [30:0]      ph_t_r    [0:3];

  logic [37:0]      kd_rem_r [0:4];
  logic [4:0]       kd_k_r   [0:4];
  logic             kd_big_r [0:4];

  logic [29:0]      ea_v_r [0:11];
  exp_ctl_t         ea_c_r [0:11];
  logic [29:0]      eb_v_r [0:11];
  logic [29:0]      eb_q_r [0:11];
  exp_ctl_t         eb_c_r [0:11];
  logic [30:0]      ec_s_r [0:11];
  exp_ctl_t         ec_c_r [0:11];

  logic [30:0]      e_r;
  logic [30:0]      e2_r;
  logic [63:0]      fp_r;
  logic             gpos_r;
  logic [31:0]      res_r;
  logic [34:0]      q_full;
  logic [31:0]      q_clip;

  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic             skid_v_r;
  logic [31:0]      skid_data_r;

  // The pipeline moves only while the skid entry is free.
  assign en        = !skid_v_r;
  assign in_tready = en;
  assign ax        = in_tdata[31] ? 32'(-in_tdata) : 32'(in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= {neg_r[LAT-1:1], in_tdata[31]};
      ax_r  <= ax;
      zp_r  <= 64'(ax_r) * 64'(ISQ2);
      up_r  <= 64'(ax_r) * 64'(ax_r);
      z_r   <= 34'((65'(zp_r) + (65'(1) << 28)) >> 29);
      u_r   <= 38'((65'(up_r) + (65'(1) << 24)) >> 25);
      pzp_r <= 64'(z_r) * 64'(P_Q30);
    end
  end

  // Reciprocal t = round(2^60 / d), one quotient bit per stage.
  assign pz    = 33'((65'(pzp_r) + (65'(1) << 29)) >> 30);
  assign d_nxt = 33'(ONE_Q30) + pz;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d_r[0]   <= d_nxt;
      dv_nlo_r[0] <= d_nxt[31:1];
      dv_rem_r[0] <= (34'd1 << 29) + 34'(d_nxt[32]);
    end
  end

  for (genvar j = 0; j <= 30; j++) begin : g_div
    logic [33:0] sh;
    logic        hit;
    logic [30:0] q_in;
    assign sh   = {dv_rem_r[j][32:0], dv_nlo_r[j][30-j]};
    assign hit  = sh >= {1'b0, dv_d_r[j]};
    if (j == 0) begin : g_q0
      assign q_in = '0;
    end else begin : g_qn
      assign q_in = dv_q_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_q_r[j+1] <= {q_in[29:0], hit};
      end
    end
    if (j < 30) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1] <= hit ? sh - {1'b0, dv_d_r[j]} : sh;
          dv_d_r[j+1]   <= dv_d_r[j];
          dv_nlo_r[j+1] <= dv_nlo_r[j];
        end
      end
    end
  end

  // Horner evaluation of the erfc polynomial in t, one multiply per step, no add in the last.
  for (genvar h = 0; h <= 4; h++) begin : g_poly
    poly_t       s_in;
    logic [30:0] t_in;
    logic [32:0] mag;
    logic [33:0] rnd;
    poly_t       sgn;
    if (h == 0) begin : g_first
      assign s_in = A5_Q30;
      assign t_in = dv_q_r[31];
    end else begin : g_next
      assign s_in = ph_s_r[h-1];
      assign t_in = ph_t_r[h-1];
    end
    assign mag = s_in[33] ? 33'(-s_in) : 33'(s_in);
    assign rnd = 34'((65'(pa_prod_r[h]) + (65'(1) << 29)) >> 30);
    assign sgn = pa_neg_r[h] ? -$signed(rnd) : $signed(rnd);
    always_ff @(posedge clk) begin
      if (en) begin
        pa_prod_r[h] <= 64'(mag) * 64'(t_in);
        pa_neg_r[h]  <= s_in[33];
      end
    end
    if (h < 4) begin : g_add
      always_ff @(posedge clk) begin
        if (en) begin
          pa_t_r[h] <= t_in;
          ph_s_r[h] <= sgn + HORNER_ADD[h];
          ph_t_r[h] <= pa_t_r[h];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          ph_s_r[h] <= sgn;
        end
      end
    end
  end

  // Range reduction u = k*ln2 + r by restoring division with a constant divisor.
  for (genvar j = 0; j <= 4; j++) begin : g_kdiv
    localparam logic [37:0] Step = 38'(LN2_Q30) << (4 - j);
    logic [37:0] rem_in;
    logic [4:0]  k_in;
    logic        big_in;
    logic        hit;
    if (j == 0) begin : g_first
      assign rem_in = u_r;
      assign k_in   = '0;
      assign big_in = u_r >= EXP_LIMIT;
    end else begin : g_next
      assign rem_in = kd_rem_r[j-1];
      assign k_in   = kd_k_r[j-1];
      assign big_in = kd_big_r[j-1];
    end
    assign hit = rem_in >= Step;
    always_ff @(posedge clk) begin
      if (en) begin
        kd_rem_r[j] <= hit ? rem_in - Step : rem_in;
        kd_k_r[j]   <= {k_in[3:0], hit};
        kd_big_r[j] <= big_in;
      end
    end
  end

  // exp(-r) by a twelve-term Horner series, three stages per term:
  // multiply and round, reciprocal multiply, then the quotient correction.
  for (genvar i = 0; i <= 11; i++) begin : g_exp
    localparam int unsigned Div = 12 - i;
    localparam logic [34:0] Recip = 35'((64'd1 << 34) / 64'(Div));
    logic [30:0] s_in;
    exp_ctl_t    c_in;
    logic [33:0] rem;
    logic [29:0] q_fix;
    if (i == 0) begin : g_first
      assign s_in = ONE_Q30;
      assign c_in = '{r: kd_rem_r[4][29:0], k: kd_k_r[4], big: kd_big_r[4]};
    end else begin : g_next
      assign s_in = ec_s_r[i-1];
      assign c_in = ec_c_r[i-1];
    end
    assign rem   = 34'(eb_v_r[i]) - 34'(eb_q_r[i]) * 34'(Div);
    assign q_fix = (rem >= 34'(Div)) ? eb_q_r[i] + 30'd1 : eb_q_r[i];
    always_ff @(posedge clk) begin
      if (en) begin
        ea_v_r[i] <= 30'(((62'(s_in) * 62'(c_in.r)) + (62'(1) << 29)) >> 30);
        ea_c_r[i] <= c_in;
        eb_v_r[i] <= ea_v_r[i];
        eb_q_r[i] <= 30'((66'(ea_v_r[i]) * 66'(Recip)) >> 34);
        eb_c_r[i] <= ea_c_r[i];
        ec_s_r[i] <= ONE_Q30 - 31'(q_fix);
        ec_c_r[i] <= eb_c_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ec_c_r[11].big) begin
        e_r <= '0;
      end else begin
        e_r <= 31'(({2'b00, ec_s_r[11], 1'b0} + (34'd1 << ec_c_r[11].k))
                   >> (6'(ec_c_r[11].k) + 6'd1));
      end
      e2_r   <= e_r;
      gpos_r <= !ph_s_r[4][33] && (ph_s_r[4] != '0);
      fp_r   <= 64'(ph_s_r[4][32:0]) * 64'(e2_r);
      res_r  <= neg_r[LAT-1] ? q_clip : 32'h8000_0000 - q_clip;
    end
  end

  assign q_full = gpos_r ? 35'((65'(fp_r) + (65'(1) << 29)) >> 30) : '0;
  assign q_clip = (q_full > 35'h0_8000_0000) ? 32'h8000_0000 : 32'(q_full);

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= en && vld_r[LAT];
      end
    end else if (en && vld_r[LAT]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_v_r ? skid_data_r : res_r;
    end else if (en && vld_r[LAT]) begin
      skid_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `NCA_ASSERT_IMP(a_skid_has_out, skid_v_r, out_valid_r, "skid entry full while output empty")
  `NCA_ASSERT_NXT(a_skid_catches, out_valid_r && !out_tready && en && vld_r[LAT], skid_v_r, "stalled result not caught by skid entry")
  `NCA_ASSERT_IMP(a_recip_range, vld_r[36], dv_q_r[31] <= ONE_Q30 && dv_q_r[31] != '0, "reciprocal out of range")
  `NCA_ASSERT_IMP(a_exp_range, vld_r[45], e_r <= ONE_Q30, "exponential above one")
  `NCA_ASSERT_IMP(a_cdf_range, out_valid_r, out_data_r <= 32'h8000_0000, "result above one")

endmodule

// ===== tb/sv/normal_cdf_approximation_tb.sv =====
module normal_cdf_approximation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE30 = 64'd1073741824;
  localparam longint unsigned HALF30 = 64'd536870912;
  localparam longint unsigned SQRT_HALF_SCALED = 64'd3037000500;
  localparam longint unsigned LN2_30 = 64'd744261118;
  localparam longint unsigned PCOEF = (64'd3275911 * ONE30 + 64'd5000000) / 64'd10000000;
  localparam int IDLE_LIMIT = 5000;
  localparam int PIPE_LATENCY = 48;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic signed [31:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;

  logic [31:0] cdf_expected [$];
  int mismatches;
  int results_seen;
  int idle_cycles;
  bit stall_enable;

  normal_cdf_approximation i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned coef_q30(longint unsigned n);
    return (n * ONE30 + 64'd500000000) / 64'd1000000000;
  endfunction

  function automatic longint signed round_mul(longint signed a, longint unsigned b);
    longint unsigned m;
    longint unsigned r;
    m = (a < 0) ? longint'(-a) : longint'(a);
    r = (m * b + HALF30) >> 30;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned decay_q30(longint unsigned u);
    longint unsigned k;
    longint unsigned r;
    longint unsigned s;
    k = u / LN2_30;
    r = u - k * LN2_30;
    s = ONE30;
    if (k >= 31) return 0;
    for (int n = 12; n >= 1; n--) s = ONE30 - ((s * r + HALF30) >> 30) / n;
    if (k == 0) return s;
    return (s + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic [31:0] phi_of(logic [31:0] x);
    longint unsigned ax, z, pz, d, t, u, e, q;
    longint signed s, g;
    ax = x[31] ? (64'h1_0000_0000 - x) : {32'd0, x};
    z = (ax * SQRT_HALF_SCALED + (64'd1 << 28)) >> 29;
    pz = (z * PCOEF + HALF30) >> 30;
    d = ONE30 + pz;
    t = ((64'd1 << 60) + (d >> 1)) / d;
    u = (ax * ax + (64'd1 << 24)) >> 25;
    e = decay_q30(u);
    s = coef_q30(64'd1061405429);
    s = round_mul(s, t) - longint'(coef_q30(64'd1453152027));
    s = round_mul(s, t) + longint'(coef_q30(64'd1421413741));
    s = round_mul(s, t) - longint'(coef_q30(64'd284496736));
    s = round_mul(s, t) + longint'(coef_q30(64'd254829592));
    g = round_mul(s, t);
    if (g <= 0) q = 0;
    else begin
      q = (longint'(g) * e + HALF30) >> 30;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
    end
    return x[31] ? q[31:0] : 32'(64'h8000_0000 - q);
  endfunction

  // Bursts of back-to-back beats, sometimes separated by random gaps. in_tvalid stays high
  // between the beats of a burst and is lowered only for a gap or a drain.
  int burst_left;
  task automatic send_x(logic [31:0] x);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= x;
    do @(posedge clk); while (!in_tready);
    cdf_expected.insert(cdf_expected.size(), phi_of(x));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (cdf_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes;
    logic [31:0] pts [21] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
      32'h0800_0000, 32'hF800_0000, 32'h1000_0000, 32'hF000_0000, 32'h3000_0000,
      32'hD000_0000, 32'h4000_0000, 32'hC000_0000, 32'h0400_0000, 32'hFC00_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000, 32'hFFFF_8000, 32'h4400_0000,
      32'hBC00_0000};
    foreach (pts[i]) send_x(pts[i]);
  endtask

  task automatic test_random(int count);
    logic [31:0] x;
    for (int i = 0; i < count; i++) begin
      // Mostly the interesting range below about 12 in magnitude, some full range.
      if ($urandom_range(0, 3) != 0)
        x = 32'($signed($urandom_range(0, 32'h6000_0000)) * ($urandom_range(0, 1) ? 1 : -1));
      else
        x = $urandom;
      send_x(x);
    end
  endtask

  task automatic test_pause_until_empty;
    test_random(40);
    drain();
    repeat (PIPE_LATENCY) @(posedge clk);
    test_random(40);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      // Stall on a pattern of its own: quiet stretches and heavy stalling.
      out_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (cdf_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          logic [31:0] want;
          want = cdf_expected.pop_front();
          if (want !== out_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cdf mismatch: expected %h got %h", want, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("normal_cdf_approximation verification failed");
      $finish;
    end
  end

  always @(posedge clk) if ($urandom_range(0, 63) == 0) stall_enable <= ~stall_enable;

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    stall_enable = 1'b0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_pause_until_empty();
    test_random(300);
    drain();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    $display("Covered signed extremes, zero, the saturating tails and %0d random arguments,",
      380);
    $display("with bursty input and a stalling receiver; %0d results checked.", results_seen);
    if (mismatches == 0 && cdf_expected.size() == 0)
      $display("normal_cdf_approximation verification clean");
    else
      $display("normal_cdf_approximation verification failed");
    $finish;
  end
endmodule
